[sv/id3pl_pkg.sv]
`default_nettype none
package id3pl_pkg;

  localparam int TAG_LEN_W = 28;
  localparam int OUT_W = 25;
  localparam int MAX_TAG_BYTES_DEFAULT = 16777216;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_FRAME_HDR = 3'd2;
  localparam logic [2:0] PH_SKIP      = 3'd3;
  localparam logic [2:0] PH_PIC       = 3'd4;
  localparam logic [2:0] PH_COUNT     = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  localparam logic [2:0] BS_ENC  = 3'd0;
  localparam logic [2:0] BS_FMT  = 3'd1;
  localparam logic [2:0] BS_MIME = 3'd2;
  localparam logic [2:0] BS_TYPE = 3'd3;
  localparam logic [2:0] BS_DESC = 3'd4;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOT_ID3  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_NO_PIC   = 3'd4;

  localparam logic [31:0] ID_PIC  = 32'h0050_4943;
  localparam logic [31:0] ID_APIC = 32'h4150_4943;

  typedef struct packed {
    logic [2:0]       status;
    logic [OUT_W-1:0] offset;
    logic [OUT_W-1:0] length;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0:    m = 8'h49;
      4'd1:    m = 8'h44;
      default: m = 8'h33;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/id3pl_core.sv]
`default_nettype none
module id3pl_core #(
  parameter int MAX_TAG_BYTES = id3pl_pkg::MAX_TAG_BYTES_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic [7:0]       data_byte,
  input  wire logic             start_of_file,
  input  wire logic             end_of_file,
  output logic                  res_valid,
  output id3pl_pkg::result_t    res
);

  localparam int TLW = id3pl_pkg::TAG_LEN_W;
  localparam int OW = id3pl_pkg::OUT_W;
  localparam logic [TLW-1:0] MAX_LEN = TLW'(MAX_TAG_BYTES);

  logic [2:0]     phase, phase_next;
  logic [3:0]     header_index, header_index_next;
  logic [2:0]     tag_version, tag_version_next;
  logic [TLW-1:0] tag_length, tag_length_next;
  logic [TLW-1:0] tag_seen, tag_seen_next;
  logic [3:0]     fhi, fhi_next;
  logic [31:0]    frame_ident, frame_ident_next;
  logic [31:0]    frame_length, frame_length_next;
  logic [31:0]    body_left, body_left_next;
  logic [2:0]     body_step, body_step_next;
  logic [7:0]     text_enc, text_enc_next;
  logic [1:0]     pair, pair_next;
  logic [OW-1:0]  found_start, found_start_next;
  logic [OW-1:0]  found_size, found_size_next;
  logic [2:0]     pending, pending_next;

  logic [2:0]     c_phase;
  logic [3:0]     c_hi;
  logic [2:0]     c_ver;
  logic [TLW-1:0] c_tl, c_seen, seen_inc;
  logic [3:0]     c_fhi, idlen, szlen, hs;
  logic [31:0]    c_ident, c_flen, c_left, left, id_base, len_base;
  logic [2:0]     c_step, c_pend;
  logic [7:0]     c_enc;
  logic [1:0]     c_pair;
  logic           v2, wide, found, emit;
  logic [2:0]     e_status;
  logic [OW-1:0]  e_off, e_len;

  always_comb begin
    // A start byte begins from a cleared state.
    c_phase = start_of_file ? id3pl_pkg::PH_HEADER : phase;
    c_hi    = start_of_file ? 4'd0 : header_index;
    c_ver   = start_of_file ? 3'd0 : tag_version;
    c_tl    = start_of_file ? '0 : tag_length;
    c_seen  = start_of_file ? '0 : tag_seen;
    c_fhi   = start_of_file ? 4'd0 : fhi;
    c_ident = start_of_file ? 32'd0 : frame_ident;
    c_flen  = start_of_file ? 32'd0 : frame_length;
    c_left  = start_of_file ? 32'd0 : body_left;
    c_step  = start_of_file ? 3'd0 : body_step;
    c_enc   = start_of_file ? 8'd0 : text_enc;
    c_pair  = start_of_file ? 2'd0 : pair;
    c_pend  = start_of_file ? 3'd0 : pending;

    phase_next        = c_phase;
    header_index_next = c_hi;
    tag_version_next  = c_ver;
    tag_length_next   = c_tl;
    tag_seen_next     = c_seen;
    fhi_next          = c_fhi;
    frame_ident_next  = c_ident;
    frame_length_next = c_flen;
    body_left_next    = c_left;
    body_step_next    = c_step;
    text_enc_next     = c_enc;
    pair_next         = c_pair;
    found_start_next  = start_of_file ? '0 : found_start;
    found_size_next   = start_of_file ? '0 : found_size;
    pending_next      = c_pend;

    v2       = (c_ver == 3'd2);
    idlen    = v2 ? 4'd3 : 4'd4;
    szlen    = v2 ? 4'd3 : 4'd4;
    hs       = v2 ? 4'd6 : 4'd10;
    wide     = (c_enc == 8'd1) || (c_enc == 8'd2);
    seen_inc = c_seen + 1'b1;
    left     = c_left - 32'd1;
    id_base  = (c_fhi == 4'd0) ? 32'd0 : c_ident;
    len_base = (c_fhi == 4'd0) ? 32'd0 : c_flen;
    found    = 1'b0;
    emit     = 1'b0;
    e_status = id3pl_pkg::ST_FOUND;
    e_off    = '0;
    e_len    = '0;

    if (c_phase == id3pl_pkg::PH_IDLE || c_phase == id3pl_pkg::PH_DONE) begin
      emit = 1'b0;
    end else if (c_phase == id3pl_pkg::PH_HEADER) begin
      if (c_hi < 4'd3) begin
        if (data_byte != id3pl_pkg::magic_byte(c_hi)) begin
          emit = 1'b1;
          e_status = id3pl_pkg::ST_NOT_ID3;
        end
      end else if (c_hi == 4'd3) begin
        if (data_byte < 8'd2 || data_byte > 8'd4) begin
          emit = 1'b1;
          e_status = id3pl_pkg::ST_NOT_ID3;
        end
        tag_version_next = data_byte[2:0];
      end else if (c_hi >= 4'd6) begin
        tag_length_next = {c_tl[TLW-8:0], data_byte[6:0]};
      end
      if (!emit) begin
        if (c_hi >= 4'd9) begin
          if (tag_length_next == '0 || tag_length_next > MAX_LEN) begin
            emit = 1'b1;
            e_status = id3pl_pkg::ST_BAD_SIZE;
          end else begin
            phase_next    = id3pl_pkg::PH_FRAME_HDR;
            tag_seen_next = '0;
            fhi_next      = 4'd0;
            pending_next  = id3pl_pkg::ST_NO_PIC;
          end
        end else begin
          header_index_next = c_hi + 4'd1;
        end
      end
    end else begin
      case (c_phase)
        id3pl_pkg::PH_FRAME_HDR: begin
          if (c_fhi == 4'd0 && ((c_tl - c_seen) < TLW'(10) || data_byte == 8'd0)) begin
            phase_next = id3pl_pkg::PH_COUNT;
          end else begin
            frame_ident_next  = id_base;
            frame_length_next = len_base;
            if (c_fhi < idlen) begin
              frame_ident_next = {id_base[23:0], data_byte};
            end else if (c_fhi < idlen + szlen) begin
              if (c_ver == 3'd4) begin
                frame_length_next = {len_base[24:0], data_byte[6:0]};
              end else begin
                frame_length_next = {len_base[23:0], data_byte};
              end
            end
            if (c_fhi + 4'd1 < hs) begin
              fhi_next = c_fhi + 4'd1;
            end else begin
              fhi_next = 4'd0;
              if (frame_length_next == 32'd0 ||
                  frame_length_next > 32'(c_tl - seen_inc)) begin
                phase_next = id3pl_pkg::PH_COUNT;
              end else begin
                body_left_next = frame_length_next;
                if (frame_ident_next == (v2 ? id3pl_pkg::ID_PIC : id3pl_pkg::ID_APIC)) begin
                  phase_next     = id3pl_pkg::PH_PIC;
                  body_step_next = id3pl_pkg::BS_ENC;
                  pair_next      = 2'd0;
                end else begin
                  phase_next = id3pl_pkg::PH_SKIP;
                end
              end
            end
          end
        end
        id3pl_pkg::PH_SKIP: begin
          body_left_next = left;
          if (left == 32'd0) begin
            phase_next = id3pl_pkg::PH_FRAME_HDR;
            fhi_next   = 4'd0;
          end
        end
        id3pl_pkg::PH_PIC: begin
          body_left_next = left;
          case (c_step)
            id3pl_pkg::BS_ENC: begin
              text_enc_next  = data_byte;
              body_step_next = v2 ? id3pl_pkg::BS_FMT : id3pl_pkg::BS_MIME;
              fhi_next       = 4'd0;
            end
            id3pl_pkg::BS_FMT: begin
              // Three format bytes and the picture type.
              fhi_next = c_fhi + 4'd1;
              if (fhi_next >= 4'd4) begin
                fhi_next       = 4'd0;
                body_step_next = id3pl_pkg::BS_DESC;
              end
            end
            id3pl_pkg::BS_MIME: begin
              if (data_byte == 8'd0) body_step_next = id3pl_pkg::BS_TYPE;
            end
            id3pl_pkg::BS_TYPE: begin
              body_step_next = id3pl_pkg::BS_DESC;
            end
            default: begin
              if (!wide) begin
                found = (data_byte == 8'd0) && (left != 32'd0);
              end else if (!c_pair[0]) begin
                pair_next = {data_byte == 8'd0, 1'b1};
              end else begin
                pair_next = 2'd0;
                found = c_pair[1] && (data_byte == 8'd0) && (left != 32'd0);
              end
            end
          endcase
          if (found) begin
            found_start_next = OW'(c_seen + TLW'(11));
            found_size_next  = left[OW-1:0];
            pending_next     = id3pl_pkg::ST_FOUND;
            phase_next       = id3pl_pkg::PH_COUNT;
          end else if (left == 32'd0) begin
            phase_next = id3pl_pkg::PH_COUNT;
          end
        end
        default: begin
          phase_next = c_phase;
        end
      endcase
      tag_seen_next = seen_inc;
      if (seen_inc >= c_tl) begin
        emit = 1'b1;
        if (pending_next == id3pl_pkg::ST_FOUND) begin
          e_status = id3pl_pkg::ST_FOUND;
          e_off    = found_start_next;
          e_len    = found_size_next;
        end else begin
          e_status = id3pl_pkg::ST_NO_PIC;
        end
      end
    end

    if (!emit && end_of_file &&
        c_phase != id3pl_pkg::PH_IDLE && c_phase != id3pl_pkg::PH_DONE) begin
      emit = 1'b1;
      e_status = id3pl_pkg::ST_TRUNC;
    end
    if (emit) phase_next = id3pl_pkg::PH_DONE;
  end

  assign res_valid  = in_fire && emit;
  assign res.status = e_status;
  assign res.offset = e_off;
  assign res.length = e_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= id3pl_pkg::PH_IDLE;
      header_index <= '0;
      tag_version  <= '0;
      tag_length   <= '0;
      tag_seen     <= '0;
      fhi          <= '0;
      frame_ident  <= '0;
      frame_length <= '0;
      body_left    <= '0;
      body_step    <= '0;
      text_enc     <= '0;
      pair         <= '0;
      found_start  <= '0;
      found_size   <= '0;
      pending      <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      tag_version  <= tag_version_next;
      tag_length   <= tag_length_next;
      tag_seen     <= tag_seen_next;
      fhi          <= fhi_next;
      frame_ident  <= frame_ident_next;
      frame_length <= frame_length_next;
      body_left    <= body_left_next;
      body_step    <= body_step_next;
      text_enc     <= text_enc_next;
      pair         <= pair_next;
      found_start  <= found_start_next;
      found_size   <= found_size_next;
      pending      <= pending_next;
    end
  end

  ap_header_index_bound: assert property (@(posedge clk) disable iff (rst)
    phase == id3pl_pkg::PH_HEADER |-> header_index <= 4'd9)
    else $error("header index ran past the header");

  ap_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == id3pl_pkg::PH_DONE)
    else $error("parser not finished after a result");

endmodule
`default_nettype wire

[sv/id3pl_out_reg.sv]
`default_nettype none
module id3pl_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire id3pl_pkg::result_t load_data,
  output logic                    in_ready,
  output logic                    valid,
  input  wire logic               take,
  output id3pl_pkg::result_t      data
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= load_data;
  end

  ap_status_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> data.status <= id3pl_pkg::ST_NO_PIC)
    else $error("status code out of range");

  ap_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    valid && data.status != id3pl_pkg::ST_FOUND |-> data.offset == '0 && data.length == '0)
    else $error("offset or length set without a picture");

endmodule
`default_nettype wire

[sv/id3v2_picture_frame_locator.sv]
// A result request appears on m_tvalid in the cycle after the input byte that ends it.
// Throughput: one byte per cycle unless input stalls; each byte updates all parser state.
// Input stalls only while a finished result waits in the output register and m_tready is low.
// Reset (rst, synchronous, active high) returns the parser to idle, awaiting a start byte,
// and empties the output register.
`default_nettype none
module id3v2_picture_frame_locator #(
  parameter int MAX_TAG_BYTES = id3pl_pkg::MAX_TAG_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_file
  input  wire logic        s_tuser,   // [0] start_of_file
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // [2:0] status, [27:3] picture_offset,
                                      // [52:28] picture_length, [55:53] zero
);

  logic               in_fire;
  logic               res_valid;
  id3pl_pkg::result_t res;
  id3pl_pkg::result_t out_data;

  // Every accepted byte steps the parser; a byte that ends the parse
  // also writes its result into the output register.
  assign in_fire = s_tvalid && s_tready;

  id3pl_core #(
    .MAX_TAG_BYTES(MAX_TAG_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .data_byte    (s_tdata),
    .start_of_file(s_tuser),
    .end_of_file  (s_tlast),
    .res_valid    (res_valid),
    .res          (res)
  );

  id3pl_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_data(res),
    .in_ready (s_tready),
    .valid    (m_tvalid),
    .take     (m_tready),
    .data     (out_data)
  );

  assign m_tdata = {3'b000, out_data.length, out_data.offset, out_data.status};

  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !in_fire)
    else $error("byte accepted while a result request is stalled");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;

  typedef logic [7:0] byte_t;

  localparam int unsigned TAG_LIMIT = 16777216;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam byte_t ID3_MAGIC [3] = '{8'h49, 8'h44, 8'h33};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tlast = 1'b0;   // end_of_file
  logic        s_tuser = 1'b0;   // [0] start_of_file
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;          // [2:0] status, [27:3] offset, [52:28] length, [55:53] zero

  id3v2_picture_frame_locator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shared run state.
  id3pl_pkg::result_t expected_results[$];
  byte_t       file_q[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  // Parser state as the block should hold it.
  logic [2:0]  phase;
  logic [31:0] hdr_idx, version, tag_len, tag_seen, fh_idx, frame_id, frame_len;
  logic [31:0] body_left, step, encoding, pair_state, pic_start, pic_size;
  logic [2:0]  pending;

  function automatic void clear_parser();
    phase = id3pl_pkg::PH_IDLE;
    hdr_idx = 0; version = 0; tag_len = 0; tag_seen = 0; fh_idx = 0;
    frame_id = 0; frame_len = 0; body_left = 0; step = 0; encoding = 0;
    pair_state = 0; pic_start = 0; pic_size = 0; pending = 0;
  endfunction

  function automatic void finish_file(logic [2:0] st, logic [31:0] off, logic [31:0] len);
    id3pl_pkg::result_t r;
    r.status = st;
    r.offset = off[id3pl_pkg::OUT_W-1:0];
    r.length = len[id3pl_pkg::OUT_W-1:0];
    expected_results.push_back(r);
    phase = id3pl_pkg::PH_DONE;
  endfunction

  function automatic void note_picture(logic [31:0] left);
    pic_start = 10 + tag_seen + 1;
    pic_size = left;
    pending = id3pl_pkg::ST_FOUND;
    phase = id3pl_pkg::PH_COUNT;
  endfunction

  function automatic void frame_header_step(byte_t b);
    logic [31:0] hs, idlen;
    hs = (version == 2) ? 6 : 10;
    idlen = (version == 2) ? 3 : 4;
    if (fh_idx == 0) begin
      // Too little room for a frame, or padding, ends the walk.
      if (tag_len - tag_seen < 10 || b == 0) begin
        phase = id3pl_pkg::PH_COUNT;
        return;
      end
      frame_id = 0;
      frame_len = 0;
    end
    if (fh_idx < idlen) begin
      frame_id = (frame_id << 8) | b;
    end else if (fh_idx < idlen + idlen) begin
      if (version == 4) frame_len = (frame_len << 7) | (b & 8'h7F);
      else frame_len = (frame_len << 8) | b;
    end
    if (fh_idx + 1 < hs) begin
      fh_idx = fh_idx + 1;
      return;
    end
    fh_idx = 0;
    if (frame_len == 0 || frame_len > tag_len - (tag_seen + 1)) begin
      phase = id3pl_pkg::PH_COUNT;
      return;
    end
    body_left = frame_len;
    if (frame_id == ((version == 2) ? id3pl_pkg::ID_PIC : id3pl_pkg::ID_APIC)) begin
      phase = id3pl_pkg::PH_PIC;
      step = id3pl_pkg::BS_ENC;
      pair_state = 0;
    end else begin
      phase = id3pl_pkg::PH_SKIP;
    end
  endfunction

  function automatic void picture_step(byte_t b);
    logic [31:0] left;
    bit wide, term;
    left = body_left - 1;
    wide = (encoding == 1 || encoding == 2);
    body_left = left;
    case (step)
      id3pl_pkg::BS_ENC: begin
        encoding = {24'd0, b};
        step = (version == 2) ? id3pl_pkg::BS_FMT : id3pl_pkg::BS_MIME;
        fh_idx = 0;
      end
      id3pl_pkg::BS_FMT: begin
        fh_idx = fh_idx + 1;
        if (fh_idx >= 4) begin
          fh_idx = 0;
          step = id3pl_pkg::BS_DESC;
        end
      end
      id3pl_pkg::BS_MIME: begin
        if (b == 0) step = id3pl_pkg::BS_TYPE;
      end
      id3pl_pkg::BS_TYPE: step = id3pl_pkg::BS_DESC;
      default: begin
        // The description ends in one NUL, or in an aligned NUL pair for UTF-16.
        if (!wide) begin
          if (b == 0 && left != 0) begin
            note_picture(left);
            return;
          end
        end else if (pair_state[0] == 1'b0) begin
          pair_state = (b == 0) ? 3 : 1;
        end else begin
          term = pair_state[1] && b == 0;
          pair_state = 0;
          if (term && left != 0) begin
            note_picture(left);
            return;
          end
        end
      end
    endcase
    if (left == 0) phase = id3pl_pkg::PH_COUNT;
  endfunction

  function automatic void track_byte(byte_t b, bit sof, bit eof);
    if (sof) begin
      clear_parser();
      phase = id3pl_pkg::PH_HEADER;
    end
    if (phase == id3pl_pkg::PH_IDLE || phase == id3pl_pkg::PH_DONE) return;
    if (phase == id3pl_pkg::PH_HEADER) begin
      if (hdr_idx < 3) begin
        if (b != ID3_MAGIC[hdr_idx]) begin
          finish_file(id3pl_pkg::ST_NOT_ID3, 0, 0);
          return;
        end
      end else if (hdr_idx == 3) begin
        if (b < 2 || b > 4) begin
          finish_file(id3pl_pkg::ST_NOT_ID3, 0, 0);
          return;
        end
        version = {24'd0, b};
      end else if (hdr_idx >= 6) begin
        tag_len = (tag_len << 7) | (b & 8'h7F);
      end
      if (hdr_idx >= 9) begin
        if (tag_len == 0 || tag_len > TAG_LIMIT) begin
          finish_file(id3pl_pkg::ST_BAD_SIZE, 0, 0);
          return;
        end
        phase = id3pl_pkg::PH_FRAME_HDR;
        tag_seen = 0;
        fh_idx = 0;
        pending = id3pl_pkg::ST_NO_PIC;
      end else begin
        hdr_idx = hdr_idx + 1;
      end
    end else begin
      case (phase)
        id3pl_pkg::PH_FRAME_HDR: frame_header_step(b);
        id3pl_pkg::PH_SKIP: begin
          body_left = body_left - 1;
          if (body_left == 0) begin
            phase = id3pl_pkg::PH_FRAME_HDR;
            fh_idx = 0;
          end
        end
        id3pl_pkg::PH_PIC: picture_step(b);
        default: ;
      endcase
      tag_seen = tag_seen + 1;
      if (tag_seen >= tag_len) begin
        if (pending == id3pl_pkg::ST_FOUND)
          finish_file(id3pl_pkg::ST_FOUND, pic_start, pic_size);
        else finish_file(id3pl_pkg::ST_NO_PIC, 0, 0);
        return;
      end
    end
    if (eof) finish_file(id3pl_pkg::ST_TRUNC, 0, 0);
  endfunction

  // Sends one request. tvalid stays high when the next request follows at once.
  task automatic send_byte(byte_t b, bit sof, bit eof);
    int unsigned gap;
    s_tdata <= b;
    s_tuser <= sof;
    s_tlast <= eof;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    track_byte(b, sof, eof);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_file(bit with_eof);
    for (int i = 0; i < file_q.size(); i++)
      send_byte(file_q[i], i == 0, with_eof && i == file_q.size() - 1);
  endtask

  // Result side: random stall bursts until the quiet part of the run.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  id3pl_pkg::result_t got, want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.offset = m_tdata[27:3];
      got.length = m_tdata[52:28];
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, actual status %0d offset %0d length %0d",
                 $time, got.status, got.offset, got.length);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.offset !== want.offset) begin
          error_count++;
          $display("%0t: offset expected %0d actual %0d", $time, want.offset, got.offset);
        end
        if (got.length !== want.length) begin
          error_count++;
          $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // File building helpers: put_header starts file_q; the frame helpers build into a tag queue.
  function automatic void put_header(byte_t ver, logic [27:0] size);
    file_q.delete();
    file_q.push_back(8'h49);
    file_q.push_back(8'h44);
    file_q.push_back(8'h33);
    file_q.push_back(ver);
    file_q.push_back(byte_t'($urandom_range(0, 255)));
    file_q.push_back(byte_t'($urandom_range(0, 255)));
    // Bit 7 of each size byte is dropped by the block, so it may carry noise.
    file_q.push_back({$urandom_range(0, 1) == 0, size[27:21]});
    file_q.push_back({$urandom_range(0, 1) == 0, size[20:14]});
    file_q.push_back({$urandom_range(0, 1) == 0, size[13:7]});
    file_q.push_back({$urandom_range(0, 1) == 0, size[6:0]});
  endfunction

  function automatic void put_frame(ref byte_t tag[$], input int ver, input logic [31:0] id,
                                    input byte_t body[$], input int delta);
    logic [31:0] sz;
    sz = body.size() + delta;
    if (ver != 2) tag.push_back(id[31:24]);
    tag.push_back(id[23:16]);
    tag.push_back(id[15:8]);
    tag.push_back(id[7:0]);
    if (ver == 2) begin
      tag.push_back(sz[23:16]); tag.push_back(sz[15:8]); tag.push_back(sz[7:0]);
    end else if (ver == 3) begin
      tag.push_back(sz[31:24]); tag.push_back(sz[23:16]);
      tag.push_back(sz[15:8]); tag.push_back(sz[7:0]);
    end else begin
      tag.push_back({1'b0, sz[27:21]}); tag.push_back({1'b0, sz[20:14]});
      tag.push_back({1'b0, sz[13:7]}); tag.push_back({1'b0, sz[6:0]});
      tag.push_back(8'h00); tag.push_back(8'h00);
    end
    if (ver == 3) begin
      tag.push_back(byte_t'($urandom_range(0, 255)));
      tag.push_back(byte_t'($urandom_range(0, 255)));
    end
    foreach (body[i]) tag.push_back(body[i]);
  endfunction

  function automatic void put_picture(ref byte_t tag[$], input int ver, input byte_t enc,
                                      input int desc_len, input int image_len, input int delta);
    byte_t body[$];
    int n;
    body.push_back(enc);
    if (ver == 2) begin
      repeat (3) body.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 5);
      repeat (n) body.push_back(byte_t'($urandom_range(1, 255)));
      body.push_back(8'h00);
    end
    body.push_back(byte_t'($urandom_range(0, 255)));
    if (enc == 1 || enc == 2) begin
      // A zero may sit in either byte of a pair, just not in both.
      repeat (desc_len) begin
        if ($urandom_range(0, 1) == 0) begin
          body.push_back($urandom_range(0, 3) == 0 ? 8'h00 : byte_t'($urandom_range(1, 255)));
          body.push_back(byte_t'($urandom_range(1, 255)));
        end else begin
          body.push_back(byte_t'($urandom_range(1, 255)));
          body.push_back($urandom_range(0, 3) == 0 ? 8'h00 : byte_t'($urandom_range(1, 255)));
        end
      end
      body.push_back(8'h00);
      body.push_back(8'h00);
    end else begin
      repeat (desc_len) body.push_back(byte_t'($urandom_range(1, 255)));
      body.push_back(8'h00);
    end
    repeat (image_len) body.push_back(byte_t'($urandom_range(0, 255)));
    put_frame(tag, ver, (ver == 2) ? id3pl_pkg::ID_PIC : id3pl_pkg::ID_APIC, body, delta);
  endfunction

  function automatic void put_other(ref byte_t tag[$], input int ver, input int delta);
    byte_t body[$];
    logic [31:0] id;
    int n;
    n = $urandom_range(1, 12);
    repeat (n) body.push_back(byte_t'($urandom_range(0, 255)));
    id = {byte_t'($urandom_range(65, 90)), byte_t'($urandom_range(48, 90)),
          byte_t'($urandom_range(48, 90)), byte_t'($urandom_range(48, 90))};
    if ($urandom_range(0, 7) == 0) id[23:0] = 24'($urandom);
    if (ver == 2) id[31:24] = 8'h00;
    if (id[23:16] == 8'h00 || (ver != 2 && id[31:24] == 8'h00)) id = 32'h5449_5432;
    put_frame(tag, ver, id, body, delta);
  endfunction

  function automatic int pick_delta();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(1, 300);
    if (r == 1) return -$urandom_range(1, 3);
    return 0;
  endfunction

  // A random tag: mostly well formed, with occasional broken sizes and bytes.
  function automatic void build_tag(int ver, ref logic [27:0] size_out, ref byte_t tag[$]);
    int frames, kind, pad;
    tag.delete();
    frames = $urandom_range(0, 4);
    repeat (frames) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        put_other(tag, ver, pick_delta());
      end else begin
        put_picture(tag, ver,
                     $urandom_range(0, 5) == 0 ? byte_t'($urandom_range(0, 255))
                                               : byte_t'($urandom_range(0, 3)),
                     $urandom_range(0, 4), $urandom_range(0, 10), pick_delta());
      end
    end
    pad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    repeat (pad) tag.push_back(8'h00);
    size_out = 28'(tag.size());
    if ($urandom_range(0, 9) == 0) size_out = 28'($urandom_range(1, tag.size() + 20));
    if (size_out == 0) size_out = 1;
  endfunction

  task automatic send_header_only(byte_t ver, logic [27:0] size, int keep, bit with_eof);
    put_header(ver, size);
    while (file_q.size() > keep) void'(file_q.pop_back());
    send_file(with_eof);
  endtask

  task automatic test_header_errors();
    for (int i = 0; i < 3; i++) begin
      put_header(8'd3, 28'd40);
      file_q[i] = file_q[i] ^ 8'h20;
      send_file(1'b1);
    end
    send_header_only(8'd1, 28'd40, 10, 1'b1);
    send_header_only(8'd5, 28'd40, 10, 1'b1);
    send_header_only(8'hFF, 28'd40, 10, 1'b1);
    send_header_only(8'd4, 28'd0, 10, 1'b1);
    send_header_only(8'd3, 28'd16777217, 10, 1'b1);
    send_header_only(8'd2, 28'hFFFFFFF, 10, 1'b1);
  endtask

  task automatic test_truncation();
    // Largest legal tag, cut short after its first frame bytes.
    put_header(8'd4, 28'd16777216);
    repeat (5) file_q.push_back(8'h41);
    send_file(1'b1);
    send_header_only(8'd3, 28'd40, 6, 1'b1);
    send_header_only(8'd2, 28'd40, 1, 1'b1);
  endtask

  task automatic test_pictures();
    byte_t tag[$];
    for (int v = 2; v <= 4; v++) begin
      for (int e = 0; e < 4; e++) begin
        tag.delete();
        put_other(tag, v, 0);
        put_picture(tag, v, byte_t'(e), 1, 3, 0);
        tag.push_back(8'h00);
        put_header(byte_t'(v), 28'(tag.size()));
        foreach (tag[i]) file_q.push_back(tag[i]);
        send_file(1'b1);
      end
    end
    // Picture frame that ends right at the description, with no image bytes.
    tag.delete();
    put_picture(tag, 3, 8'd0, 2, 0, 0);
    put_header(8'd3, 28'(tag.size()));
    foreach (tag[i]) file_q.push_back(tag[i]);
    send_file(1'b0);
  endtask

  task automatic test_ignored_and_restart();
    send_byte(8'h49, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_header_only(8'd3, 28'd30, 5, 1'b0);
    send_header_only(8'd3, 28'd1, 10, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
  endtask

  task automatic random_file();
    byte_t tag[$];
    logic [27:0] size;
    int ver, cut;
    ver = $urandom_range(2, 4);
    build_tag(ver, size, tag);
    put_header($urandom_range(0, 19) == 0 ? byte_t'($urandom_range(0, 255)) : byte_t'(ver),
               size);
    foreach (tag[i]) file_q.push_back(tag[i]);
    repeat ($urandom_range(0, 3)) file_q.push_back(byte_t'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = byte_t'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
    send_file($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) == 0)
      send_byte(byte_t'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_files();
    while (bytes_sent < 1500) random_file();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (8) random_file();
  endtask

  initial begin
    clear_parser();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_header_errors();
    test_truncation();
    test_pictures();
    test_ignored_and_restart();
    test_random_files();
    test_back_to_back();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
